// ===== hw/rtl/log_freq_gain_table_top_macros.svh =====
// assertion macros used by the checker file
`ifndef LOG_FREQ_GAIN_TABLE_TOP_MACROS_SVH
`define LOG_FREQ_GAIN_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked at every clock edge outside reset
`define LFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lft_pkg.sv =====
// shared types, codes and constants of the breakpoint gain table
`timescale 1ns / 1ps
`default_nettype none
package lft_pkg;

  localparam int MAX_NODES_DEF = 32;
  localparam int FREQ_W        = 21;
  localparam int GAIN_W        = 16;
  localparam int LOG_W         = 21;
  localparam int DIFF_W        = LOG_W + 1;
  localparam int DG_W          = GAIN_W + 1;
  localparam int NUM_W         = DIFF_W + DG_W;
  localparam int FRAC_BITS     = 16;
  localparam int MANT_W        = 31;
  localparam int DATA_W        = 40;

  // ln 2 in Q32, rounded
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // action codes
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_QUERY  = 3'd2;
  localparam logic [2:0] ACT_FIND   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic        [FREQ_W-1:0] freq;
    logic signed [GAIN_W-1:0] gain;
  } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lft_log.sv =====
// iterative natural-log unit: leading one, sixteen squaring rounds, ln 2 scale; inputs below 32 bypass
`timescale 1ns / 1ps
`default_nettype none
module lft_log (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [lft_pkg::FREQ_W-1:0] x,
  output logic                           done,
  output logic [lft_pkg::LOG_W-1:0]      result
);

  logic [lft_pkg::MANT_W-1:0]    m_r, m_nxt, mant;
  logic [lft_pkg::FRAC_BITS-1:0] frac_r;
  logic [4:0]                    e_r, lead;
  logic [3:0]                    rnd_r;
  logic                          run_r, fin_r, done_r;
  logic [lft_pkg::LOG_W-1:0]     res_r;
  logic [2*lft_pkg::MANT_W-1:0]  sq;
  logic [lft_pkg::MANT_W:0]      m2;
  logic                          bit_c;
  logic [lft_pkg::LOG_W-1:0]     l2;
  logic [lft_pkg::LOG_W+31:0]    prod;

  // leading one of the input
  always_comb begin
    lead = '0;
    for (int i = 0; i < lft_pkg::FREQ_W; i++) begin
      if (x[i]) lead = 5'(i);
    end
    mant = lft_pkg::MANT_W'(x) << (5'd30 - lead);
  end

  // one squaring round per cycle
  always_comb begin
    sq = m_r * m_r;
    m2 = sq[2*lft_pkg::MANT_W-1:30];
    bit_c = m2[lft_pkg::MANT_W];
    m_nxt = bit_c ? m2[lft_pkg::MANT_W:1] : m2[lft_pkg::MANT_W-1:0];
  end

  // scale log2 by ln 2
  always_comb begin
    l2 = {5'(e_r - 5'd4), frac_r};
    prod = (lft_pkg::LOG_W + 32)'(l2) * (lft_pkg::LOG_W + 32)'(lft_pkg::LN2_Q32);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (x < lft_pkg::FREQ_W'(32)) begin
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
        end
      end else if (run_r && rnd_r == 4'd15) begin
        run_r <= 1'b0;
        fin_r <= 1'b1;
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      m_r    <= mant;
      e_r    <= lead;
      frac_r <= '0;
      rnd_r  <= '0;
      res_r  <= lft_pkg::LOG_W'({x[4:0], 12'b0});
    end else if (run_r) begin
      m_r <= m_nxt;
      frac_r[4'd15 - rnd_r] <= bit_c;
      rnd_r <= rnd_r + 4'd1;
    end else if (fin_r) begin
      res_r <= prod[lft_pkg::LOG_W+31:32];
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lft_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module lft_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [lft_pkg::NUM_W-1:0]  dividend,
  input  wire logic [lft_pkg::DIFF_W-1:0] divisor,
  output logic                            done,
  output logic [lft_pkg::NUM_W-1:0]       quotient
);

  logic [lft_pkg::NUM_W-1:0]  quo_r;
  logic [lft_pkg::DIFF_W-1:0] rem_r, dvs_r;
  logic [lft_pkg::DIFF_W:0]   rem_sh;
  logic [5:0]                 cnt_r;
  logic                       run_r, done_r;
  logic                       ge;

  assign rem_sh = {rem_r, quo_r[lft_pkg::NUM_W-1]};
  assign ge     = rem_sh >= (lft_pkg::DIFF_W + 1)'(dvs_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 6'(lft_pkg::NUM_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? lft_pkg::DIFF_W'(rem_sh - (lft_pkg::DIFF_W + 1)'(dvs_r))
                  : rem_sh[lft_pkg::DIFF_W-1:0];
      quo_r <= {quo_r[lft_pkg::NUM_W-2:0], ge};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/log_freq_gain_table_top.sv =====
// top level: breakpoint table memory, sequencer and output register
//
// Equalizer breakpoint table. One input beat on in_* carries an action
// (insert, remove, query, find, clear), a frequency and a node gain; each
// accepted beat yields exactly one result beat on out_* with status, gain,
// found index and node count. Handshakes are tvalid/tready.
// The table sits in a single-port-read, single-port-write memory with a
// registered read, so every entry visit takes a read state and a following
// check or write state. Insert walks down from the top, moving each larger
// node up one place; find scans up from the bottom; remove scans, then
// shifts the nodes above down; clear only resets the node count.
// query scans from the bottom and, when interpolating, runs three log
// evaluations (inputs below 32 Hz take a short path), a multiply and a
// division of 39 quotient bits.
// One item is worked on at a time; in_tready is high while the sequencer
// is idle, even when the previous result still waits in the output register.
// A stalled receiver holds the result in the output register; a finished
// item then waits until that register frees before the next one is taken.
// Reset empties the table; entry contents are not cleared and are never read
// above the node count.
`timescale 1ns / 1ps
`default_nettype none
module log_freq_gain_table_top #(
  parameter int MAX_NODES = lft_pkg::MAX_NODES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // action[2:0], freq_hz[23:3], node_gain[39:24]
  input  wire logic [lft_pkg::DATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // status[1:0], gain_db[17:2], found_index[25:18], node_total[34:26], zero pad
  output logic [lft_pkg::DATA_W-1:0]       out_tdata
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_INS_RD   = 15'b000000000000010,
    S_INS_WR   = 15'b000000000000100,
    S_INS_PUT  = 15'b000000000001000,
    S_SRCH_RD  = 15'b000000000010000,
    S_SRCH_CHK = 15'b000000000100000,
    S_SHF_RD   = 15'b000000001000000,
    S_SHF_WR   = 15'b000000010000000,
    S_LOG      = 15'b000000100000000,
    S_LOG_WAIT = 15'b000001000000000,
    S_INTERP   = 15'b000010000000000,
    S_MUL      = 15'b000100000000000,
    S_DIV      = 15'b001000000000000,
    S_DIV_WAIT = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]                          in_action;
  logic [lft_pkg::FREQ_W-1:0]          in_freq;
  logic signed [lft_pkg::GAIN_W-1:0]   in_gain;

  logic [2:0]                          act_r, act_nxt;
  logic [lft_pkg::FREQ_W-1:0]          freq_r, freq_nxt;
  logic signed [lft_pkg::GAIN_W-1:0]   gain_r, gain_nxt;
  logic [CW-1:0]                       held_r, held_nxt;
  logic [CW-1:0]                       idx_r, idx_nxt, idx_p1;
  lft_pkg::entry_t                     left_r, left_nxt, right_r, right_nxt;
  logic [1:0]                          lsel_r, lsel_nxt;
  logic [lft_pkg::LOG_W-1:0]           lq_r, lq_nxt, ll_r, ll_nxt, lr_r, lr_nxt;
  logic signed [lft_pkg::DIFF_W-1:0]   n_r, n_nxt, d_r, d_nxt, n_c, d_c;
  logic signed [lft_pkg::DG_W-1:0]     dg_r, dg_nxt;
  logic signed [lft_pkg::NUM_W-1:0]    num_r, num_nxt, mag_c;
  logic                                neg_r, neg_nxt;
  logic [1:0]                          res_status_r, res_status_nxt;
  logic signed [lft_pkg::GAIN_W-1:0]   res_gain_r, res_gain_nxt;
  logic [7:0]                          res_found_r, res_found_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [lft_pkg::DATA_W-1:0]          out_data_r, out_data_nxt;
  logic signed [lft_pkg::NUM_W+1:0]    q_c, sum_c;

  // table memory
  lft_pkg::entry_t mem [MAX_NODES];
  lft_pkg::entry_t rd_data_r, wd;
  logic            we, re;
  logic [AW-1:0]   wa, ra;

  // log and divide units
  logic                        log_start, log_done;
  logic [lft_pkg::FREQ_W-1:0]  log_x;
  logic [lft_pkg::LOG_W-1:0]   log_res;
  logic                        div_start, div_done;
  logic [lft_pkg::NUM_W-1:0]   div_num, div_quo;
  logic [lft_pkg::DIFF_W-1:0]  div_den;

  lft_log u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  lft_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // input unpacking
  assign in_action = in_tdata[2:0];
  assign in_freq   = in_tdata[23:3];
  assign in_gain   = in_tdata[39:24];
  assign idx_p1    = CW'(idx_r + 1'b1);
  assign in_tready = (state_r == S_IDLE);

  // memory ports
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data_r <= mem[ra];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    freq_nxt       = freq_r;
    gain_nxt       = gain_r;
    held_nxt       = held_r;
    idx_nxt        = idx_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    lsel_nxt       = lsel_r;
    lq_nxt         = lq_r;
    ll_nxt         = ll_r;
    lr_nxt         = lr_r;
    n_nxt          = n_r;
    d_nxt          = d_r;
    dg_nxt         = dg_r;
    num_nxt        = num_r;
    neg_nxt        = neg_r;
    res_status_nxt = res_status_r;
    res_gain_nxt   = res_gain_r;
    res_found_nxt  = res_found_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    we             = 1'b0;
    wa             = '0;
    wd             = rd_data_r;
    re             = 1'b0;
    ra             = '0;
    log_start      = 1'b0;
    log_x          = freq_r;
    div_start      = 1'b0;
    n_c            = $signed({1'b0, lq_r}) - $signed({1'b0, ll_r});
    d_c            = $signed({1'b0, lr_r}) - $signed({1'b0, ll_r});
    mag_c          = (num_r < 0) ? -num_r : num_r;
    div_num        = lft_pkg::NUM_W'(mag_c) + lft_pkg::NUM_W'(d_r[lft_pkg::DIFF_W-1:1]);
    div_den        = d_r;
    q_c            = neg_r ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    sum_c          = (lft_pkg::NUM_W + 2)'(left_r.gain) + q_c;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt        = in_action;
          freq_nxt       = in_freq;
          gain_nxt       = in_gain;
          res_status_nxt = lft_pkg::ST_OK;
          res_gain_nxt   = '0;
          res_found_nxt  = '0;
          state_nxt      = S_DONE;
          if (in_action == lft_pkg::ACT_INSERT) begin
            if (held_r == CW'(MAX_NODES)) begin
              res_status_nxt = lft_pkg::ST_FULL;
            end else if (held_r == '0) begin
              we       = 1'b1;
              wa       = '0;
              wd       = '{freq: in_freq, gain: in_gain};
              held_nxt = CW'(held_r + 1'b1);
            end else begin
              idx_nxt   = CW'(held_r - 1'b1);
              state_nxt = S_INS_RD;
            end
          end else if (in_action inside {lft_pkg::ACT_REMOVE, lft_pkg::ACT_QUERY,
                                         lft_pkg::ACT_FIND}) begin
            if (held_r == '0) begin
              res_status_nxt = lft_pkg::ST_EMPTY;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_SRCH_RD;
            end
          end else if (in_action == lft_pkg::ACT_CLEAR) begin
            held_nxt = '0;
          end
        end
      end
      // walk down from the top, moving larger entries up one place
      S_INS_RD: begin
        re        = 1'b1;
        ra        = idx_r[AW-1:0];
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        we = 1'b1;
        wa = AW'(idx_p1);
        if (rd_data_r.freq > freq_r) begin
          wd = rd_data_r;
          if (idx_r == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            idx_nxt   = CW'(idx_r - 1'b1);
            state_nxt = S_INS_RD;
          end
        end else begin
          wd        = '{freq: freq_r, gain: gain_r};
          held_nxt  = CW'(held_r + 1'b1);
          state_nxt = S_DONE;
        end
      end
      S_INS_PUT: begin
        we        = 1'b1;
        wa        = '0;
        wd        = '{freq: freq_r, gain: gain_r};
        held_nxt  = CW'(held_r + 1'b1);
        state_nxt = S_DONE;
      end
      // linear scan from the bottom
      S_SRCH_RD: begin
        re        = 1'b1;
        ra        = idx_r[AW-1:0];
        state_nxt = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (act_r == lft_pkg::ACT_QUERY) begin
          if (rd_data_r.freq >= freq_r) begin
            if (idx_r == '0 || left_r.gain == rd_data_r.gain) begin
              res_gain_nxt = rd_data_r.gain;
              state_nxt    = S_DONE;
            end else begin
              right_nxt = rd_data_r;
              lsel_nxt  = '0;
              state_nxt = S_LOG;
            end
          end else begin
            left_nxt = rd_data_r;
            if (idx_p1 == held_r) begin
              res_gain_nxt = rd_data_r.gain;
              state_nxt    = S_DONE;
            end else begin
              idx_nxt   = idx_p1;
              state_nxt = S_SRCH_RD;
            end
          end
        end else begin
          if (rd_data_r.freq == freq_r) begin
            if (act_r == lft_pkg::ACT_FIND) begin
              res_found_nxt = 8'(idx_r);
              state_nxt     = S_DONE;
            end else begin
              state_nxt = S_SHF_RD;
            end
          end else if (idx_p1 == held_r) begin
            res_status_nxt = lft_pkg::ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = S_SRCH_RD;
          end
        end
      end
      // close the gap left by a removed entry
      S_SHF_RD: begin
        if (idx_p1 >= held_r) begin
          held_nxt  = CW'(held_r - 1'b1);
          state_nxt = S_DONE;
        end else begin
          re        = 1'b1;
          ra        = AW'(idx_p1);
          state_nxt = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        we        = 1'b1;
        wa        = idx_r[AW-1:0];
        wd        = rd_data_r;
        idx_nxt   = idx_p1;
        state_nxt = S_SHF_RD;
      end
      // log of query, left and right frequencies in turn
      S_LOG: begin
        log_start = 1'b1;
        case (lsel_r)
          2'd0:    log_x = freq_r;
          2'd1:    log_x = left_r.freq;
          default: log_x = right_r.freq;
        endcase
        state_nxt = S_LOG_WAIT;
      end
      S_LOG_WAIT: begin
        if (log_done) begin
          case (lsel_r)
            2'd0:    lq_nxt = log_res;
            2'd1:    ll_nxt = log_res;
            default: lr_nxt = log_res;
          endcase
          if (lsel_r == 2'd2) begin
            state_nxt = S_INTERP;
          end else begin
            lsel_nxt  = lsel_r + 2'd1;
            state_nxt = S_LOG;
          end
        end
      end
      // spans, sign folded into the numerator
      S_INTERP: begin
        dg_nxt = lft_pkg::DG_W'(right_r.gain) - lft_pkg::DG_W'(left_r.gain);
        if (d_c == '0) begin
          res_gain_nxt = left_r.gain;
          state_nxt    = S_DONE;
        end else begin
          n_nxt     = (d_c < 0) ? -n_c : n_c;
          d_nxt     = (d_c < 0) ? -d_c : d_c;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        num_nxt   = n_r * dg_r;
        state_nxt = S_DIV;
      end
      // rounded magnitude division
      S_DIV: begin
        div_start = 1'b1;
        neg_nxt   = (num_r < 0);
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (sum_c > (lft_pkg::NUM_W + 2)'(32767)) begin
            res_gain_nxt = 16'sh7FFF;
          end else if (sum_c < -(lft_pkg::NUM_W + 2)'(32768)) begin
            res_gain_nxt = 16'sh8000;
          end else begin
            res_gain_nxt = lft_pkg::GAIN_W'(sum_c);
          end
          state_nxt = S_DONE;
        end
      end
      // hand the result to the output register when it frees
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {5'b0, 9'(held_r), res_found_r, res_gain_r, res_status_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    freq_r       <= freq_nxt;
    gain_r       <= gain_nxt;
    idx_r        <= idx_nxt;
    left_r       <= left_nxt;
    right_r      <= right_nxt;
    lsel_r       <= lsel_nxt;
    lq_r         <= lq_nxt;
    ll_r         <= ll_nxt;
    lr_r         <= lr_nxt;
    n_r          <= n_nxt;
    d_r          <= d_nxt;
    dg_r         <= dg_nxt;
    num_r        <= num_nxt;
    neg_r        <= neg_nxt;
    res_status_r <= res_status_nxt;
    res_gain_r   <= res_gain_nxt;
    res_found_r  <= res_found_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lft_checker.sv =====
// port-level checks of the breakpoint table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "log_freq_gain_table_top_macros.svh"
module lft_checker #(
  parameter int MAX_NODES = lft_pkg::MAX_NODES_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic [lft_pkg::DATA_W-1:0] in_tdata,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [lft_pkg::DATA_W-1:0] out_tdata
);

  logic [1:0] o_status;
  logic [8:0] o_total;

  assign o_status = out_tdata[1:0];
  assign o_total  = out_tdata[34:26];

  // a stalled result beat holds
  `LFT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed under stall")
  // node count never exceeds the table size
  `LFT_ASSERT_NOW(a_total_max, out_tvalid, o_total <= 9'(MAX_NODES), "node count above table size")
  // full status only with a full table
  `LFT_ASSERT_NOW(a_full_total, out_tvalid && o_status == lft_pkg::ST_FULL, o_total == 9'(MAX_NODES), "full status with free entries")
  // a found index or a gain comes only with ok status
  `LFT_ASSERT_NOW(a_found_ok, out_tvalid && out_tdata[25:18] != 8'd0, o_status == lft_pkg::ST_OK, "found index with error status")
  `LFT_ASSERT_NOW(a_gain_ok, out_tvalid && out_tdata[17:2] != 16'd0, o_status == lft_pkg::ST_OK, "gain with error status")

endmodule

bind log_freq_gain_table_top lft_checker #(.MAX_NODES(MAX_NODES)) u_lft_checker (.*);
`default_nettype wire
